// ===== hw/rtl/circle_circle_contact_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CIRCLE_CIRCLE_CONTACT_ASSERT_SVH
`define CIRCLE_CIRCLE_CONTACT_ASSERT_SVH

// Implication checked on every clock, muted while reset is asserted.
`define CCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ccc_pkg.sv =====
`default_nettype none
package ccc_pkg;
    localparam int unsigned CoordW = 32;
    localparam int unsigned RadW   = 31;
    localparam int unsigned NormW  = 16;
    localparam int unsigned DepthW = 32;
    // Packed payload widths, zero filled to whole bytes.
    localparam int unsigned InDataW  = 192;
    localparam int unsigned OutDataW = 200;
    // Operand and root widths of the two square-root pipelines.
    localparam int unsigned SqrtInW  = 66;
    localparam int unsigned SqrtOutW = 33;
    // Radix-2 quotient bits for the Q1.14 normal (0..16384 rounded).
    localparam int unsigned QuoW = 16;
endpackage
`default_nettype wire

// ===== hw/rtl/ccc_sqrt.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage, with a
// side-band payload that travels along with the operand.
module ccc_sqrt
    import ccc_pkg::*;
#(
    parameter int unsigned InW   = SqrtInW,
    parameter int unsigned SideW = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [InW-1:0]     i_val,
    input  wire logic [SideW-1:0]   i_side,
    output logic [InW/2-1:0]        o_root,
    output logic [SideW-1:0]        o_side
);
    localparam int unsigned OutW = InW / 2;

    logic [InW-1:0]   r_rad  [OutW+1];
    logic [OutW+1:0]  r_rem  [OutW+1];
    logic [OutW-1:0]  r_root [OutW+1];
    logic [SideW-1:0] r_side [OutW+1];

    always_comb begin
        r_rad[0]  = i_val;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < OutW; s++) begin : g_stage
        logic [OutW+1:0] n_trial;
        logic [OutW+1:0] n_rem;
        logic [OutW-1:0] n_root;
        logic [OutW+1:0] n_sub;
        always_comb begin
            n_trial = {r_rem[s][OutW-1:0], r_rad[s][InW-1 -: 2]};
            n_sub   = {r_root[s], 2'b01};
            if (n_trial >= n_sub) begin
                n_rem  = n_trial - n_sub;
                n_root = {r_root[s][OutW-2:0], 1'b1};
            end else begin
                n_rem  = n_trial;
                n_root = {r_root[s][OutW-2:0], 1'b0};
            end
        end
        logic [InW-1:0]   r_rad_q;
        logic [OutW+1:0]  r_rem_q;
        logic [OutW-1:0]  r_root_q;
        logic [SideW-1:0] r_side_q;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad_q  <= {r_rad[s][InW-3:0], 2'b00};
                r_rem_q  <= n_rem;
                r_root_q <= n_root;
                r_side_q <= r_side[s];
            end
        end
        always_comb begin
            r_rad[s+1]  = r_rad_q;
            r_rem[s+1]  = r_rem_q;
            r_root[s+1] = r_root_q;
            r_side[s+1] = r_side_q;
        end
    end

    assign o_root = r_root[OutW];
    assign o_side = r_side[OutW];
endmodule
`default_nettype wire

// ===== hw/rtl/ccc_div.sv =====
`default_nettype none
// Pipelined restoring divider for the normal: q = round(m * 16384 / len),
// one quotient bit per stage, ties away from zero (numerator biased by len/2).
module ccc_div
    import ccc_pkg::*;
#(
    parameter int unsigned SideW = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [SqrtOutW-1:0] i_mag,
    input  wire logic [SqrtOutW-1:0] i_len,
    input  wire logic [SideW-1:0]    i_side,
    output logic [QuoW-1:0]          o_quo,
    output logic [SideW-1:0]         o_side
);
    // |d| <= len, so the quotient stays at or under 16384 and fits QuoW bits.
    localparam int unsigned NumW = SqrtOutW + 15;
    localparam int unsigned RemW = SqrtOutW + 1;

    logic [NumW-1:0]     r_num  [QuoW+1];
    logic [RemW-1:0]     r_rem  [QuoW+1];
    logic [QuoW-1:0]     r_quo  [QuoW+1];
    logic [SqrtOutW-1:0] r_den  [QuoW+1];
    logic [SideW-1:0]    r_side [QuoW+1];

    logic [NumW-1:0] n_num0;
    always_comb begin
        n_num0 = {i_mag, 14'd0} + NumW'(i_len >> 1);
        // Pre-shift so the top QuoW bits are consumed after the first
        // NumW-QuoW bits, which are provably below len, seed the remainder.
        r_rem[0]  = RemW'(n_num0[NumW-1:QuoW]);
        r_num[0]  = {n_num0[QuoW-1:0], {(NumW-QuoW){1'b0}}};
        r_quo[0]  = '0;
        r_den[0]  = i_len;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < QuoW; s++) begin : g_stage
        logic [RemW:0]   n_trial;
        logic [RemW-1:0] n_rem;
        logic            n_bit;
        always_comb begin
            n_trial = {r_rem[s], r_num[s][NumW-1]};
            n_bit   = (n_trial >= {1'b0, 1'b0, r_den[s]});
            n_rem   = n_bit ? RemW'(n_trial - {2'b00, r_den[s]}) : RemW'(n_trial);
        end
        logic [NumW-1:0]     r_num_q;
        logic [RemW-1:0]     r_rem_q;
        logic [QuoW-1:0]     r_quo_q;
        logic [SqrtOutW-1:0] r_den_q;
        logic [SideW-1:0]    r_side_q;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num_q  <= {r_num[s][NumW-2:0], 1'b0};
                r_rem_q  <= n_rem;
                r_quo_q  <= {r_quo[s][QuoW-2:0], n_bit};
                r_den_q  <= r_den[s];
                r_side_q <= r_side[s];
            end
        end
        always_comb begin
            r_num[s+1]  = r_num_q;
            r_rem[s+1]  = r_rem_q;
            r_quo[s+1]  = r_quo_q;
            r_den[s+1]  = r_den_q;
            r_side[s+1] = r_side_q;
        end
    end

    assign o_quo  = r_quo[QuoW];
    assign o_side = r_side[QuoW];
endmodule
`default_nettype wire

// ===== hw/rtl/circle_circle_contact.sv =====
`default_nettype none
// Circle-circle contact unit.
// Input stream (s_axis_*): one circle pair per request, tdata packs
// a_x, a_y, a_radius, b_x, b_y, b_radius from bit 0 up (Q16.16).
// Output stream (m_axis_*): one contact result per pair, tdata packs
// hit, coincident, normal_x, normal_y, start_x, start_y, end_x, end_y, depth.
// Throughput: one request per cycle when the receiver takes results.
// Pipeline: 2 + 33 + 16 + 3 + 2 + 33 = 89 register stages ahead of the
// output register, set by the two 33-stage square roots and the
// 16-stage quotient pipeline for the normal.
// The whole pipeline advances as one: when the output register holds an
// unaccepted result, every stage freezes and s_axis_tready drops, so nothing
// is lost or repeated. An empty output slot always lets the pipe move.
// Reset (synchronous, active low) clears every valid bit; payload registers
// are not reset. No result leaves a missed pair but zeros with hit low.
// Coincident centres give hit and coincident high, zero normal, start at B,
// end at A and zero depth. Points saturate to signed 32 bits and depth to
// all ones.
module circle_circle_contact
    import ccc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // a_x, a_y, a_radius, b_x, b_y, b_radius, zero pad
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // hit, coincident, normal_x, normal_y, start_x, start_y, end_x, end_y,
    // depth, zero pad
    output logic [OutDataW-1:0]      m_axis_tdata
);
    localparam int unsigned Lat1 = SqrtOutW;  // first root
    localparam int unsigned Lat2 = QuoW;      // normal divide
    localparam int unsigned Lat3 = SqrtOutW;  // depth root
    localparam int unsigned NV   = 2 + Lat1 + Lat2 + 3 + 2 + Lat3;

    logic en;
    logic [NV-1:0] r_vld;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Valid bits travel in a shift line matching the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], s_axis_tvalid};
        end
    end

    // ---- stage P: differences, magnitudes, radius sum
    logic signed [31:0] in_ax, in_ay, in_bx, in_by;
    logic [30:0] in_ra, in_rb;
    assign in_ax = s_axis_tdata[31:0];
    assign in_ay = s_axis_tdata[63:32];
    assign in_ra = s_axis_tdata[94:64];
    assign in_bx = s_axis_tdata[126:95];
    assign in_by = s_axis_tdata[158:127];
    assign in_rb = s_axis_tdata[189:159];

    logic signed [32:0] n_dx, n_dy;
    logic [31:0] n_rsum;
    assign n_dx = 33'(in_bx) - 33'(in_ax);
    assign n_dy = 33'(in_by) - 33'(in_ay);
    assign n_rsum = {1'b0, in_ra} + {1'b0, in_rb};

    logic [32:0] n_mx, n_my;
    assign n_mx = n_dx[32] ? 33'(-n_dx) : 33'(n_dx);
    assign n_my = n_dy[32] ? 33'(-n_dy) : 33'(n_dy);

    typedef struct packed {
        logic signed [31:0] ax, ay, bx, by;
        logic [30:0]        ra, rb;
        logic signed [32:0] dx, dy;
        logic [32:0]        mx, my;
        logic [31:0]        rsum;
    } t_pre;

    t_pre r_p0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0.ax <= in_ax; r_p0.ay <= in_ay;
            r_p0.bx <= in_bx; r_p0.by <= in_by;
            r_p0.ra <= in_ra; r_p0.rb <= in_rb;
            r_p0.dx <= n_dx;  r_p0.dy <= n_dy;
            r_p0.mx <= n_mx;  r_p0.my <= n_my;
            r_p0.rsum <= n_rsum;
        end
    end

    // ---- stage 0: squares
    typedef struct packed {
        logic signed [31:0] ax, ay, bx, by;
        logic [30:0]        ra, rb;
        logic signed [32:0] dx, dy;
        logic [63:0]        r2;
    } t_geo;

    t_geo r_g0;
    logic [65:0] r_d2;

    // dx^2 + dy^2 needs up to 66 bits; squares are 33x33, registered.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g0.ax <= r_p0.ax; r_g0.ay <= r_p0.ay;
            r_g0.bx <= r_p0.bx; r_g0.by <= r_p0.by;
            r_g0.ra <= r_p0.ra; r_g0.rb <= r_p0.rb;
            r_g0.dx <= r_p0.dx; r_g0.dy <= r_p0.dy;
            r_g0.r2 <= 64'(r_p0.rsum) * 64'(r_p0.rsum);
            r_d2    <= 66'(r_p0.mx) * 66'(r_p0.mx) + 66'(r_p0.my) * 66'(r_p0.my);
        end
    end

    typedef struct packed {
        t_geo g;
        logic hit;
    } t_s1;

    t_s1 n_s1, r_s1;
    assign n_s1.g   = r_g0;
    assign n_s1.hit = (r_d2 <= {2'b00, r_g0.r2});

    logic [SqrtOutW-1:0] sq1_root;
    ccc_sqrt #(.InW(SqrtInW), .SideW($bits(t_s1))) u_len (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_d2),
        .i_side (n_s1),
        .o_root (sq1_root),
        .o_side (r_s1)
    );

    // ---- normal: two dividers share the pipeline beat
    logic coin;
    logic [SqrtOutW-1:0] len_safe;
    assign coin     = (sq1_root == '0);
    assign len_safe = coin ? SqrtOutW'(1) : sq1_root;

    typedef struct packed {
        t_s1  s;
        logic coin;
        logic sgn_y;
        logic [SqrtOutW-1:0] my;
    } t_d;

    t_d n_d, r_dx_side, r_dy_side;
    assign n_d.s     = r_s1;
    assign n_d.coin  = coin;
    assign n_d.sgn_y = r_s1.g.dy[32];
    assign n_d.my    = r_s1.g.dy[32] ? 33'(-r_s1.g.dy) : 33'(r_s1.g.dy);

    logic [SqrtOutW-1:0] mdx;
    assign mdx = r_s1.g.dx[32] ? 33'(-r_s1.g.dx) : 33'(r_s1.g.dx);

    logic [QuoW-1:0] qx, qy;
    ccc_div #(.SideW($bits(t_d))) u_divx (
        .i_clk (i_clk), .i_en (en), .i_mag (mdx), .i_len (len_safe),
        .i_side (n_d), .o_quo (qx), .o_side (r_dx_side)
    );
    ccc_div #(.SideW($bits(t_d))) u_divy (
        .i_clk (i_clk), .i_en (en), .i_mag (n_d.my), .i_len (len_safe),
        .i_side (n_d), .o_quo (qy), .o_side (r_dy_side)
    );

    // ---- stage N1: signed normal
    logic signed [NormW-1:0] n_nx, n_ny;
    always_comb begin
        if (r_dx_side.coin || !r_dx_side.s.hit) begin
            n_nx = '0;
            n_ny = '0;
        end else begin
            n_nx = r_dx_side.s.g.dx[32] ? NormW'(-qx) : NormW'(qx);
            n_ny = r_dx_side.s.g.dy[32] ? NormW'(-qy) : NormW'(qy);
        end
    end

    t_d r_n1;
    logic signed [NormW-1:0] r_nx1, r_ny1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n1 <= r_dx_side; r_nx1 <= n_nx; r_ny1 <= n_ny;
        end
    end

    // ---- stage N2: scaled offsets (15x31 multiplies)
    logic [14:0] mnx, mny;
    assign mnx = r_nx1[15] ? 15'(-r_nx1) : 15'(r_nx1);
    assign mny = r_ny1[15] ? 15'(-r_ny1) : 15'(r_ny1);

    logic [45:0] r_pxb, r_pyb, r_pxa, r_pya;
    t_d r_n2;
    logic r_sx2, r_sy2;
    logic signed [NormW-1:0] r_nx2, r_ny2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxb <= 46'(mnx) * 46'(r_n1.s.g.rb);
            r_pyb <= 46'(mny) * 46'(r_n1.s.g.rb);
            r_pxa <= 46'(mnx) * 46'(r_n1.s.g.ra);
            r_pya <= 46'(mny) * 46'(r_n1.s.g.ra);
            r_sx2 <= r_nx1[15]; r_sy2 <= r_ny1[15];
            r_nx2 <= r_nx1; r_ny2 <= r_ny1;
            r_n2  <= r_n1;
        end
    end

    // ---- stage N3: points with saturation
    function automatic logic signed [31:0] sat_pt(input logic signed [31:0] base,
            input logic [45:0] prod, input logic neg);
        logic [32:0] q;
        logic signed [34:0] v;
        q = 33'((prod + 46'd8192) >> 14);
        v = neg ? 35'(base) - 35'(q) : 35'(base) + 35'(q);
        if (v > 35'sd2147483647)       sat_pt = 32'h7FFFFFFF;
        else if (v < -35'sd2147483648) sat_pt = 32'h80000000;
        else                           sat_pt = v[31:0];
    endfunction

    logic signed [31:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [NormW-1:0] r_nx3, r_ny3;
    logic r_hit3, r_coin3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            // start = B - n*rb, end = A + n*ra
            r_sx <= sat_pt(r_n2.s.g.bx, r_pxb, !r_sx2);
            r_sy <= sat_pt(r_n2.s.g.by, r_pyb, !r_sy2);
            r_ex <= sat_pt(r_n2.s.g.ax, r_pxa, r_sx2);
            r_ey <= sat_pt(r_n2.s.g.ay, r_pya, r_sy2);
            r_nx3 <= r_nx2; r_ny3 <= r_ny2;
            r_hit3 <= r_n2.s.hit; r_coin3 <= r_n2.coin;
        end
    end

    // ---- depth: differences, then squares, then root
    logic signed [32:0] edx, edy;
    logic [32:0] medx, medy;
    assign edx  = 33'(r_ex) - 33'(r_sx);
    assign edy  = 33'(r_ey) - 33'(r_sy);
    assign medx = edx[32] ? 33'(-edx) : 33'(edx);
    assign medy = edy[32] ? 33'(-edy) : 33'(edy);

    typedef struct packed {
        logic hit, coin;
        logic signed [15:0] nx, ny;
        logic signed [31:0] sx, sy, ex, ey;
    } t_res;

    t_res n_r, r_res;
    assign n_r = '{hit: r_hit3, coin: r_coin3, nx: r_nx3, ny: r_ny3,
                   sx: r_sx, sy: r_sy, ex: r_ex, ey: r_ey};

    logic [32:0] r_mdx, r_mdy;
    t_res r_rm;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mdx <= medx; r_mdy <= medy; r_rm <= n_r;
        end
    end

    logic [65:0] e2;
    assign e2 = 66'(r_mdx) * 66'(r_mdx) + 66'(r_mdy) * 66'(r_mdy);

    logic [65:0] r_e2;
    t_res r_rq;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e2 <= e2; r_rq <= r_rm;
        end
    end

    logic [SqrtOutW-1:0] dep_root;
    ccc_sqrt #(.InW(SqrtInW), .SideW($bits(t_res))) u_dep (
        .i_clk  (i_clk), .i_en (en), .i_val (r_e2), .i_side (r_rq),
        .o_root (dep_root), .o_side (r_res)
    );

    // ---- output register
    logic [31:0] dep_sat;
    assign dep_sat = dep_root[32] ? 32'hFFFFFFFF : dep_root[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= r_vld[NV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_res.hit) begin
                m_axis_tdata <= {2'b00, dep_sat, r_res.ey, r_res.ex, r_res.sy,
                                 r_res.sx, r_res.ny, r_res.nx, r_res.coin, 1'b1};
            end else begin
                m_axis_tdata <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ccc_checker.sv =====
`default_nettype none
`include "circle_circle_contact_assert.svh"
// Port-level checks of the contact unit.
module ccc_checker
    import ccc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OutDataW-1:0] m_axis_tdata
);
    `CCC_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata == '0, "miss result not all zero")
    `CCC_ASSERT_IMPL(a_coin_hit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0] && m_axis_tdata[33:2] == '0, "coincident without hit or with normal")
    `CCC_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with free output")
    `CCC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind circle_circle_contact ccc_checker u_ccc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== verif/tb_circle_circle_contact.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Contact unit bench: random bursts of circle pairs in, random stalls out,
// every result checked field by field against an in-bench contact predictor.
module tb_circle_circle_contact;
    import ccc_pkg::*;

    typedef struct packed {
        logic [1:0]  pad;
        logic [30:0] b_radius;
        logic [31:0] b_y;
        logic [31:0] b_x;
        logic [30:0] a_radius;
        logic [31:0] a_y;
        logic [31:0] a_x;
    } t_pair;

    typedef struct packed {
        logic        hit;
        logic        coincident;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [31:0] depth;
    } t_contact;

    localparam int unsigned Latency = 90;
    localparam longint CycleLimit = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // a_x, a_y, a_radius, b_x, b_y, b_radius, zero pad
    logic [InDataW-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // hit, coincident, normal_x, normal_y, start_x, start_y, end_x, end_y,
    // depth, zero pad
    logic [OutDataW-1:0] m_axis_tdata;

    circle_circle_contact uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_pair    pending_pairs[$];
    t_contact expected_contacts[$];
    int       mismatches;
    int       results_seen;
    int       hits_seen;
    int       coincident_seen;
    longint   cycle_count;
    bit       stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Integer square root, floor, of an unsigned 66-bit value.
    function automatic logic [32:0] isqrt66(input logic [65:0] v);
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] bitv;
        rem = v;
        root = '0;
        bitv = 66'd1 << 64;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[32:0];
    endfunction

    // Exact squared length of a vector whose parts fit in 33 signed bits.
    function automatic logic [65:0] sq_len(input logic signed [33:0] x,
                                           input logic signed [33:0] y);
        logic [33:0] ax;
        logic [33:0] ay;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        return 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    endfunction

    function automatic logic signed [33:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 34'sd2147483647;
        if (v < -34'sd2147483648) return -34'sd2147483648;
        return v;
    endfunction

    // Q1.14 normal times Q16.16 radius, rounded half away from zero.
    function automatic logic signed [33:0] offset(input logic signed [16:0] n,
                                                  input logic [30:0] r);
        logic [47:0] p;
        logic [33:0] q;
        p = 48'(n < 0 ? -n : n) * 48'(r);
        q = 34'((p + 48'd8192) >> 14);
        return n < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [16:0] unit_part(input logic signed [33:0] d,
                                                     input logic [32:0] len);
        logic [49:0] q;
        q = (50'(d < 0 ? -d : d) * 50'd16384 + 50'(len >> 1)) / 50'(len);
        return d < 0 ? -$signed(17'(q)) : $signed(17'(q));
    endfunction

    function automatic t_contact predict_contact(input t_pair p);
        t_contact c;
        logic signed [33:0] ax, ay, bx, by, dx, dy, sx, sy, ex, ey;
        logic [30:0] ra, rb;
        logic [65:0] d2, r2, e2;
        logic [32:0] len, dep;
        logic signed [16:0] nx, ny;
        c = '{default: '0};
        ax = 34'($signed(p.a_x)); ay = 34'($signed(p.a_y));
        bx = 34'($signed(p.b_x)); by = 34'($signed(p.b_y));
        ra = p.a_radius; rb = p.b_radius;
        dx = bx - ax; dy = by - ay;
        d2 = sq_len(dx, dy);
        r2 = 66'(32'(ra) + 32'(rb)) * 66'(32'(ra) + 32'(rb));
        if (d2 >= 66'h1_0000_0000_0000_0000 || d2 > r2) return c;
        len = isqrt66(d2);
        nx = '0; ny = '0;
        if (len != 0) begin
            nx = unit_part(dx, len);
            ny = unit_part(dy, len);
        end
        sx = sat32(bx - offset(nx, rb));
        sy = sat32(by - offset(ny, rb));
        ex = sat32(ax + offset(nx, ra));
        ey = sat32(ay + offset(ny, ra));
        e2 = sq_len(ex - sx, ey - sy);
        // full-scale difference overflows 64 bits: depth pins to all ones
        if (e2 >= 66'h1_0000_0000_0000_0000) dep = 33'hFFFF_FFFF;
        else dep = isqrt66(e2);
        if (dep > 33'hFFFF_FFFF) dep = 33'hFFFF_FFFF;
        c.hit = 1'b1;
        c.coincident = (len == 0);
        c.normal_x = nx[15:0]; c.normal_y = ny[15:0];
        c.start_x = sx[31:0]; c.start_y = sy[31:0];
        c.end_x = ex[31:0]; c.end_y = ey[31:0];
        c.depth = dep[31:0];
        return c;
    endfunction

    function automatic t_pair make_pair(input logic [31:0] ax, ay, ar, bx, by, br);
        t_pair p;
        p.pad = '0;
        p.a_x = ax; p.a_y = ay; p.a_radius = ar[30:0];
        p.b_x = bx; p.b_y = by; p.b_radius = br[30:0];
        return p;
    endfunction

    // Value biased toward small, edge and full-range numbers.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    // Random pair; most are built to overlap so the contact path is busy.
    function automatic t_pair rand_pair();
        logic [31:0] ax, ay, bx, by, ra, rb;
        ax = rand_coord(); ay = rand_coord();
        ra = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000);
        rb = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000);
        case ($urandom_range(0, 9))
            0, 1: begin bx = rand_coord(); by = rand_coord(); end
            2: begin bx = ax; by = ay; end
            default: begin
                bx = ax + 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
                by = ay + 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            end
        endcase
        return make_pair(ax, ay, ra, bx, by, rb);
    endfunction

    // Stimulus: directed corners, then random pairs.
    initial begin
        stimulus_done = 1'b0;
        // hit by exact touch, just apart, coincident
        pending_pairs.push_back(make_pair(0, 0, 32'h1_0000, 32'h2_0000, 0, 32'h1_0000));
        pending_pairs.push_back(make_pair(0, 0, 32'h1_0000, 32'h2_0001, 0, 32'h1_0000));
        pending_pairs.push_back(make_pair(5, -7, 0, 5, -7, 0));
        pending_pairs.push_back(make_pair(32'h100, 32'h100, 32'h7FFF_FFFF,
                                          32'h100, 32'h100, 32'h7FFF_FFFF));
        // opposite corners and edges: no hit with zero radii or with max radii
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 0,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          0, 32'h8000_0000, 32'h7FFF_FFFF));
        // axis-aligned and diagonal normals, negative directions
        pending_pairs.push_back(make_pair(0, 0, 32'h3_0000, 0, -32'sh1_0000, 32'h1_0000));
        pending_pairs.push_back(make_pair(0, 0, 32'h3_0000, 32'h1_0000, 32'h1_0000, 32'h1));
        pending_pairs.push_back(make_pair(0, 0, 32'h3_0000, -32'sh1, -32'sh1, 0));
        pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h8000_0010, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555,
                                          32'hFFFF_FFFF, 32'h0, 32'h2AAA_AAAA));
        repeat (650) pending_pairs.push_back(rand_pair());
        stimulus_done = 1'b1;
    end

    // Request accepted at the last rising edge.
    logic s_axis_tready_seen;
    always @(posedge i_clk) begin
        s_axis_tready_seen <= s_axis_tvalid && s_axis_tready && i_rst_n;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_contacts.push_back(predict_contact(t_pair'(s_axis_tdata[191:0])));
    end

    // Sender: bursts of requests with random gaps.
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            end
            if (burst_left > 0 && pending_pairs.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= InDataW'(pending_pairs.pop_front());
                burst_left--;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // Receiver stall pattern: alternating free-running and choppy stretches.
    int stall_phase;
    always @(negedge i_clk) begin
        stall_phase = stall_phase + 1;
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if ((stall_phase / 300) % 3 == 0) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) < 65);
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_contact got;
        t_contact want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit        = m_axis_tdata[0];
            got.coincident = m_axis_tdata[1];
            got.normal_x   = m_axis_tdata[17:2];
            got.normal_y   = m_axis_tdata[33:18];
            got.start_x    = m_axis_tdata[65:34];
            got.start_y    = m_axis_tdata[97:66];
            got.end_x      = m_axis_tdata[129:98];
            got.end_y      = m_axis_tdata[161:130];
            got.depth      = m_axis_tdata[193:162];
            results_seen++;
            if (expected_contacts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_contacts.pop_front();
                hits_seen += want.hit;
                coincident_seen += want.coincident;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch\n  exp %p\n  got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        s_axis_tready_seen = 1'b0;
        stall_phase = 0;
        mismatches = 0;
        results_seen = 0;
        hits_seen = 0;
        coincident_seen = 0;
        cycle_count = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        wait (stimulus_done && pending_pairs.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid || expected_contacts.size() != 0) @(posedge i_clk);
        repeat (2 * Latency) @(posedge i_clk);
        $display("%0d pairs checked: %0d hits, %0d with coincident centres",
                 results_seen, hits_seen, coincident_seen);
        if (mismatches == 0 && expected_contacts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
